// File: design/aimd_pkg.sv
// ----------------------------------------------------------------------------
// aimd_pkg
// Shared constants and types for the AIMD congestion window block.
// ----------------------------------------------------------------------------
package aimd_pkg;

    // Outstanding ring; depth must be a power of two
    localparam int RING_DEPTH = 1024;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam int CW         = AW + 1;

    // Divider operand widths: (gain << 16) / window
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Configuration register indexes
    localparam logic [7:0] REG_TIMEOUT  = 8'd0;
    localparam logic [7:0] REG_DECREASE = 8'd1;
    localparam logic [7:0] REG_GAIN     = 8'd2;
    localparam logic [7:0] REG_MIN_WIN  = 8'd3;

    // Opcodes
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    // Reset values
    localparam logic [15:0] RST_TIMEOUT  = 16'd1000;
    localparam logic [15:0] RST_DECREASE = 16'd45875;
    localparam logic [19:0] RST_GAIN     = 20'd78643;
    localparam logic [15:0] RST_MIN_WIN  = 16'd2;
    localparam logic [31:0] RST_WINDOW   = 32'd655360;

    // One ring entry
    typedef struct packed {
        logic        acked;
        logic [31:0] send_time;
        logic [31:0] seq;
    } t_entry;

endpackage

// File: design/aimd_div.sv
// ----------------------------------------------------------------------------
// aimd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aimd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aimd_pkg::DIV_NW-1:0]   i_dividend,
    input  logic [aimd_pkg::DIV_DW-1:0]   i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [aimd_pkg::DIV_NW-1:0]   o_quot
);
    import aimd_pkg::*;

    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;

    // shift in the next dividend bit and trial-subtract
    assign w_sh = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DW'(w_sh - {1'b0, r_div}) : w_sh[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// File: design/aimd_congestion_window.sv
// ----------------------------------------------------------------------------
// aimd_congestion_window
// Sender-side AIMD congestion window with a ring of outstanding datagrams.
// ----------------------------------------------------------------------------
// Input channel (s_axis): tuser carries the opcode (0 send, 1 ack); tdata
// carries sequence number and timestamp. One item is taken at a time.
// Output channel (m_axis): one result per item - integer window, timeout
// flag and status (send dropped on a full ring).
// Config channel: register index and data, always ready; write only while idle.
// Sequence: a send goes straight to the result. An ack walks the ring in a
// single-port memory: it reads and checks entries until the match, retires
// acked entries from the oldest end and checks the age of the oldest kept
// one, then multiplies on timeout or adds the bit-serial gain/window divide,
// then clamps to the minimum window.
// The divider and the ring port walk set the rate.
// Reset clears window (10.0), ring pointers and config; ring memory needs
// no clearing, as only entries written by a send are ever read.
// When the receiver stalls, the result waits in the output register; the
// next item is taken meanwhile and its result waits internally.
// ----------------------------------------------------------------------------
module aimd_congestion_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] seq number, [63:32] timestamp
    input  logic        i_s_axis_tuser,   // [0] opcode
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] window, [16] timed_out,
                                          // [17] status, [23:18] zero
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import aimd_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_S_RD  = 4'd1;
    localparam logic [3:0] ST_S_CHK = 4'd2;
    localparam logic [3:0] ST_R_RD  = 4'd3;
    localparam logic [3:0] ST_R_CHK = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_CLAMP = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // config registers
    logic [15:0] r_timeout;
    logic [15:0] r_decrease;
    logic [19:0] r_gain;
    logic [15:0] r_min_win;

    // control state
    logic [3:0]    r_state;
    logic [31:0]   r_window;
    logic [AW-1:0] r_oldest;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_k;
    logic          r_timed;
    logic          r_status;
    logic          r_out_valid;

    // payload
    logic [31:0]   r_seq;
    logic [31:0]   r_stamp;
    logic [AW-1:0] r_addr;
    logic [47:0]   r_prod;
    logic [15:0]   r_out_win;
    logic          r_out_timed;
    logic          r_out_status;

    // ring memory
    t_entry        r_mem [RING_DEPTH];
    t_entry        r_rd_data;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    // divider
    logic              w_div_start;
    logic              w_div_busy;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_div_quot;
    logic [DIV_NW:0]   w_sum;
    logic [31:0]       w_age;
    logic              w_accept;
    logic              w_out_load;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);
    assign w_sum      = {1'b0, 4'd0, r_window} + {1'b0, w_div_quot};
    assign w_age      = r_stamp - r_rd_data.send_time;

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_rd_data;
        w_re    = 1'b0;
        w_raddr = r_oldest;
        case (r_state)
            ST_IDLE: begin
                w_we               = w_accept && (i_s_axis_tuser == OP_SEND)
                                     && (r_count != CW'(RING_DEPTH));
                w_waddr            = r_oldest + r_count[AW-1:0];
                w_wdata.acked      = 1'b0;
                w_wdata.send_time  = i_s_axis_tdata[63:32];
                w_wdata.seq        = i_s_axis_tdata[31:0];
            end
            ST_S_RD: begin
                w_re    = (r_k != r_count);
                w_raddr = r_oldest + r_k[AW-1:0];
            end
            ST_S_CHK: begin
                w_we          = !r_rd_data.acked && (r_rd_data.seq == r_seq);
                w_wdata.acked = 1'b1;
            end
            ST_R_RD: begin
                w_re = (r_count != '0);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= RST_TIMEOUT;
            r_decrease <= RST_DECREASE;
            r_gain     <= RST_GAIN;
            r_min_win  <= RST_MIN_WIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                REG_DECREASE: r_decrease <= i_cfg_data[15:0];
                REG_GAIN:     r_gain     <= i_cfg_data;
                REG_MIN_WIN:  r_min_win  <= i_cfg_data[15:0];
                default:      r_timeout  <= r_timeout;
            endcase
        end
    end

    assign w_div_start = (r_state == ST_UPD) && !r_timed && (r_window != '0);

    aimd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_gain, 16'd0}),
        .i_divisor  (r_window),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_window <= RST_WINDOW;
            r_oldest <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_timed  <= 1'b0;
            r_status <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_timed  <= 1'b0;
                        r_status <= 1'b0;
                        r_k      <= '0;
                        if (i_s_axis_tuser == OP_SEND) begin
                            if (r_count == CW'(RING_DEPTH)) begin
                                r_status <= 1'b1;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_S_RD;
                        end
                    end
                end
                ST_S_RD: begin
                    r_state <= (r_k == r_count) ? ST_R_RD : ST_S_CHK;
                end
                ST_S_CHK: begin
                    if (!r_rd_data.acked && (r_rd_data.seq == r_seq)) begin
                        r_state <= ST_R_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= ST_S_RD;
                    end
                end
                ST_R_RD: begin
                    if (r_count == '0) begin
                        r_timed <= 1'b0;
                        r_state <= ST_UPD;
                    end else begin
                        r_state <= ST_R_CHK;
                    end
                end
                ST_R_CHK: begin
                    if (r_rd_data.acked) begin
                        r_oldest <= r_oldest + 1'b1;
                        r_count  <= r_count - 1'b1;
                        r_state  <= ST_R_RD;
                    end else begin
                        r_timed <= (w_age > {16'd0, r_timeout});
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_timed) begin
                        r_state <= ST_MUL;
                    end else if (r_window == '0) begin
                        r_window <= '1;
                        r_state  <= ST_CLAMP;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_MUL: begin
                    r_window <= r_prod[47:16];
                    r_state  <= ST_CLAMP;
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_window <= (w_sum[DIV_NW:32] != '0) ? '1 : w_sum[31:0];
                        r_state  <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    if (r_window < {r_min_win, 16'd0}) begin
                        r_window <= {r_min_win, 16'd0};
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // item payload and product
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seq   <= i_s_axis_tdata[31:0];
            r_stamp <= i_s_axis_tdata[63:32];
        end
        if (r_state == ST_S_RD) begin
            r_addr <= r_oldest + r_k[AW-1:0];
        end
        if (r_state == ST_UPD) begin
            r_prod <= 48'(r_window) * 48'(r_decrease);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_win    <= r_window[31:16];
            r_out_timed  <= r_timed;
            r_out_status <= r_status;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_status, r_out_timed, r_out_win};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(RING_DEPTH))
        else $error("outstanding count beyond ring depth");

    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (w_div_busy || w_div_done))
        else $error("waiting on an idle divider");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLAMP) |=> (r_window >= {r_min_win, 16'd0}))
        else $error("window below minimum after clamp");

    a_send_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == OP_SEND) |=> (r_timed == 1'b0))
        else $error("timeout flagged on a send");
`endif

endmodule

// File: test/aimd_window_checker.sv
// ----------------------------------------------------------------------------
// aimd_window_checker
// Watches the item, result and register channels of the congestion window
// block, keeps its own copy of the outstanding ring and the window, predicts
// each result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module aimd_window_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import aimd_pkg::*;

    typedef struct packed {
        logic        status;
        logic        timed_out;
        logic [15:0] win_int;
    } t_window_result;

    // Predictor copy of the registers and state
    logic [15:0] timeout_q;
    logic [15:0] decrease_q;
    logic [19:0] gain_q;
    logic [15:0] min_win_q;
    logic [31:0] win_q16;
    logic [31:0] ring_seq  [RING_DEPTH];
    logic [31:0] ring_time [RING_DEPTH];
    logic        ring_ack  [RING_DEPTH];
    int unsigned head_idx;
    int unsigned in_flight;

    t_window_result expected_results[$];

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    // Work out the result of one item and advance the predictor state
    function automatic t_window_result predict_window(input logic op,
                                                      input logic [31:0] seq,
                                                      input logic [31:0] stamp);
        t_window_result r;
        int unsigned    slot;
        logic [31:0]    age;
        logic [63:0]    prod;
        logic [63:0]    stepv;
        logic [63:0]    sum;
        r = '0;
        if (op == OP_SEND) begin
            if (in_flight >= RING_DEPTH) begin
                r.status = 1'b1;
            end else begin
                slot = (head_idx + in_flight) % RING_DEPTH;
                ring_seq[slot]  = seq;
                ring_time[slot] = stamp;
                ring_ack[slot]  = 1'b0;
                in_flight++;
            end
        end else begin
            // mark oldest matching unacked entry
            for (int k = 0; k < in_flight; k++) begin
                slot = (head_idx + k) % RING_DEPTH;
                if (!ring_ack[slot] && ring_seq[slot] == seq) begin
                    ring_ack[slot] = 1'b1;
                    break;
                end
            end
            // retire acked entries from the oldest end
            while (in_flight > 0 && ring_ack[head_idx]) begin
                ring_ack[head_idx] = 1'b0;
                head_idx = (head_idx + 1) % RING_DEPTH;
                in_flight--;
            end
            if (in_flight > 0) begin
                age = stamp - ring_time[head_idx];
                if (age > {16'd0, timeout_q}) r.timed_out = 1'b1;
            end
            if (r.timed_out) begin
                prod = {32'd0, win_q16} * {48'd0, decrease_q};
                win_q16 = prod[47:16];
            end else begin
                if (win_q16 == 0) stepv = 64'hFFFF_FFFF;
                else stepv = ({44'd0, gain_q} << 16) / {32'd0, win_q16};
                sum = {32'd0, win_q16} + stepv;
                win_q16 = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
            if (win_q16 < {min_win_q, 16'd0}) win_q16 = {min_win_q, 16'd0};
        end
        r.win_int = win_q16[31:16];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_window_result got;
        t_window_result want;
        if (!i_rst_n) begin
            timeout_q  <= RST_TIMEOUT;
            decrease_q <= RST_DECREASE;
            gain_q     <= RST_GAIN;
            min_win_q  <= RST_MIN_WIN;
            win_q16    = RST_WINDOW;
            head_idx   = 0;
            in_flight  = 0;
            for (int i = 0; i < RING_DEPTH; i++) ring_ack[i] = 1'b0;
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TIMEOUT:  timeout_q  <= i_cfg_data[15:0];
                    REG_DECREASE: decrease_q <= i_cfg_data[15:0];
                    REG_GAIN:     gain_q     <= i_cfg_data;
                    REG_MIN_WIN:  min_win_q  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // accepted item
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_window(i_s_tuser, i_s_tdata[31:0],
                                                          i_s_tdata[63:32]));
            // accepted result
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[17:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", {14'd0, got}, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.win_int !== want.win_int)
                        report_mismatch("win_int", {16'd0, got.win_int},
                                        {16'd0, want.win_int});
                    if (got.timed_out !== want.timed_out)
                        report_mismatch("timed_out", {31'd0, got.timed_out},
                                        {31'd0, want.timed_out});
                    if (got.status !== want.status)
                        report_mismatch("status", {31'd0, got.status},
                                        {31'd0, want.status});
                    if (i_m_tdata[23:18] !== 6'd0)
                        report_mismatch("tdata padding", {26'd0, i_m_tdata[23:18]}, 32'd0);
                end
            end
        end
    end

endmodule

// File: test/tb_aimd_congestion_window.sv
// ----------------------------------------------------------------------------
// tb_aimd_congestion_window
// Drives sends and acks into the congestion window block through several
// register settings and idle patterns; a checker beside it predicts results.
// ----------------------------------------------------------------------------
module tb_aimd_congestion_window;
    import aimd_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [19:0] cfg_data;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_req;
    logic        hold_taken = 1'b0;
    int          hold_off = 0;
    int          idle_cycles = 0;
    logic [31:0] clock_ms;
    logic [31:0] next_seq;
    logic [31:0] sent_seqs[$];

    aimd_congestion_window u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    aimd_window_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Receiver: random stalls, or one long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_off > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one item and wait until it is taken
    task automatic send_item(input logic op, input logic [31:0] seq,
                             input logic [31:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {stamp, seq};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
    endtask

    // Register write, only issued while the block is idle
    task automatic write_reg(input logic [7:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for all results, then let a trailing ack's work settle
    task automatic drain;
        int guard;
        guard = 0;
        while (pending != 0 && guard < STALL_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (100) @(negedge i_clk);
    endtask

    // Well-formed traffic: sends with rising time, acks of outstanding
    // sequence numbers, some out of order, some stray or late
    task automatic random_traffic(input int n);
        int          pick;
        logic [31:0] seq;
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(40);
            if (sent_seqs.size() == 0 || ($urandom_range(99) < 50
                                          && sent_seqs.size() < 40)) begin
                seq = ($urandom_range(9) == 0) ? $urandom() : next_seq;
                next_seq++;
                sent_seqs.push_back(seq);
                send_item(OP_SEND, seq, ($urandom_range(19) == 0) ? $urandom() : clock_ms);
            end else if ($urandom_range(9) == 0) begin
                send_item(OP_ACK, $urandom(),
                          ($urandom_range(4) == 0) ? clock_ms + 32'd3000 : clock_ms);
            end else begin
                pick = ($urandom_range(2) == 0) ? $urandom_range(sent_seqs.size() - 1) : 0;
                seq = sent_seqs[pick];
                sent_seqs.delete(pick);
                send_item(OP_ACK, seq,
                          ($urandom_range(7) == 0) ? clock_ms + $urandom_range(5000) : clock_ms);
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_SEND;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TIMEOUT;
        cfg_data       = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clock_ms       = 32'd100;
        next_seq       = 32'd1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, both operations, special cases
        send_item(OP_SEND, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        send_item(OP_SEND, 32'h0, 32'h0);
        send_item(OP_SEND, 32'h5, 32'h10);
        send_item(OP_SEND, 32'h5, 32'h20);          // duplicate sequence
        send_item(OP_ACK, 32'h5, 32'h30);           // marks the older duplicate
        send_item(OP_ACK, 32'h1234_5678, 32'h40);   // no match, wrapped age stays under the timeout
        send_item(OP_ACK, 32'hFFFF_FFFF, 32'h50);   // retire oldest
        send_item(OP_ACK, 32'h0, 32'hFFFF_FFFF);    // old entry times out
        send_item(OP_ACK, 32'h5, 32'h60);           // ring empties: growth
        send_item(OP_ACK, 32'hAAAA_5555, 32'h5555_AAAA); // empty ring ack
        drain();

        // Minimum zero, decrease factor zero: window collapses then saturates
        write_reg(REG_MIN_WIN, 20'd0);
        write_reg(REG_DECREASE, 20'd0);
        write_reg(REG_TIMEOUT, 20'd0);
        send_item(OP_SEND, 32'h7, 32'h0);
        send_item(OP_ACK, 32'h8, 32'h5);
        send_item(OP_ACK, 32'h7, 32'h6);
        drain();
        write_reg(REG_GAIN, 20'hFFFFF);
        send_item(OP_ACK, 32'h9, 32'h7);
        send_item(OP_ACK, 32'h9, 32'h8);
        drain();

        // A long hold-off on the result side backs the block up
        write_reg(REG_MIN_WIN, 20'hFFFF);
        write_reg(REG_TIMEOUT, 20'hFFFF);
        write_reg(REG_DECREASE, 20'hFFFF);
        write_reg(REG_GAIN, 20'd0);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_item(OP_SEND, i, i);
        for (int i = 0; i < 40; i++) send_item(OP_ACK, i, 32'd50);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            write_reg(REG_TIMEOUT, 20'($urandom_range(ph == 0 ? 0 : 400)));
            write_reg(REG_DECREASE, 20'($urandom_range(65535)));
            write_reg(REG_GAIN, (ph == 3) ? 20'hFFFFF : 20'($urandom_range(300000)));
            write_reg(REG_MIN_WIN, 20'($urandom_range(1, 12)));
            random_traffic(60);
            // flush outstanding acks so phases start with a short ring
            while (sent_seqs.size() > 0) begin
                send_item(OP_ACK, sent_seqs.pop_front(), clock_ms);
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
